FILE: rtl/xmr_pkg.sv
// Package for the XMODEM receiver: phases, sync modes, pending actions,
// line characters and the CRC-16 byte update. No dependencies.
package xmr_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SYNC    = 3'd1,
    PH_CANWAIT = 3'd2,
    PH_BLOCK   = 3'd3,
    PH_FLUSH   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    MODE_C    = 2'd0,
    MODE_NAK  = 2'd1,
    MODE_NONE = 2'd2
  } sync_mode_t;

  typedef enum logic [2:0] {
    PEND_NONE     = 3'd0,
    PEND_END      = 3'd1,
    PEND_CANCEL   = 3'd2,
    PEND_SYNCFAIL = 3'd3,
    PEND_DUPS     = 3'd4,
    PEND_NAK      = 3'd5
  } pend_t;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] KIND_SEND   = 2'd0;
  localparam logic [1:0] KIND_STORE  = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  localparam logic [1:0] ST_NORMAL   = 2'd0;
  localparam logic [1:0] ST_CANCEL   = 2'd1;
  localparam logic [1:0] ST_SYNCFAIL = 2'd2;
  localparam logic [1:0] ST_DUPS     = 2'd3;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_C   = 8'h43;

  localparam logic [2:0] FLUSH_MAX = 3'd5;
  localparam logic [10:0] SMALL_BLK = 11'd128;
  localparam logic [10:0] LARGE_BLK = 11'd1024;

  localparam logic [2:0] REG_DEST  = 3'd0;
  localparam logic [2:0] REG_SYNCW = 3'd1;
  localparam logic [2:0] REG_BYTEW = 3'd2;
  localparam logic [2:0] REG_FLUSHW = 3'd3;
  localparam logic [2:0] REG_TRIES = 3'd4;
  localparam logic [2:0] REG_RETR  = 3'd5;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [23:0] addr;
    logic [1:0]  status;
    logic [23:0] len;
  } res_t;

  // Result list from one step, up to four entries.
  typedef struct packed {
    logic [2:0]    count;
    res_t [3:0]    item;
  } res_list_t;

  // XMODEM CRC-16, polynomial 0x1021, one byte, high bit first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: rtl/xmr_core.sv
// Protocol step logic of the XMODEM receiver: session state and the
// results of one input item. Depends on xmr_pkg.
module xmr_core #(
  parameter int ADDR_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [1:0]          op,
  input  logic [7:0]          rx_byte,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [23:0]         cfg_data,
  output xmr_pkg::res_list_t  res
);
  import xmr_pkg::*;

  // Configuration registers.
  logic [23:0] dest_size_r;
  logic [15:0] sync_wait_r, byte_wait_r, flush_wait_r;
  logic [7:0]  sync_tries_r, max_retrans_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_size_r <= 24'd65536; sync_wait_r <= 16'd2000; byte_wait_r <= 16'd1000;
      flush_wait_r <= 16'd1500; sync_tries_r <= 8'd16; max_retrans_r <= 8'd25;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DEST:   dest_size_r <= cfg_data;
        REG_SYNCW:  sync_wait_r <= cfg_data[15:0];
        REG_BYTEW:  byte_wait_r <= cfg_data[15:0];
        REG_FLUSHW: flush_wait_r <= cfg_data[15:0];
        REG_TRIES:  sync_tries_r <= cfg_data[7:0];
        REG_RETR:   max_retrans_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Capacity is the destination size clipped to the address space.
  logic [24:0] cap;
  always_comb begin
    if (ADDR_BITS >= 24) cap = {1'b0, dest_size_r};
    else if ({1'b0, dest_size_r} > (25'd1 << ADDR_BITS)) cap = 25'd1 << ADDR_BITS;
    else cap = {1'b0, dest_size_r};
  end

  phase_t      phase_r, phase_nxt;
  sync_mode_t  mode_r, mode_nxt;
  pend_t       pend_r, pend_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [7:0]  sync_cnt_r, sync_cnt_nxt;
  logic        crc_mode_r, crc_mode_nxt;
  logic [7:0]  exp_blk_r, exp_blk_nxt;
  logic [10:0] idx_r, idx_nxt;
  logic        large_r, large_nxt;
  logic [7:0]  blk_num_r, blk_num_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] rchk_r, rchk_nxt;
  logic [23:0] clen_r, clen_nxt;
  logic [7:0]  dup_r, dup_nxt;
  logic [2:0]  flush_cnt_r, flush_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; mode_r <= MODE_C; pend_r <= PEND_NONE; timer_r <= '0;
      sync_cnt_r <= '0; crc_mode_r <= 1'b0; exp_blk_r <= 8'd1; idx_r <= '0;
      large_r <= 1'b0; blk_num_r <= '0; hdr_ok_r <= 1'b0; crc_r <= '0; sum_r <= '0;
      rchk_r <= '0; clen_r <= '0; dup_r <= '0; flush_cnt_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt; mode_r <= mode_nxt; pend_r <= pend_nxt; timer_r <= timer_nxt;
      sync_cnt_r <= sync_cnt_nxt; crc_mode_r <= crc_mode_nxt; exp_blk_r <= exp_blk_nxt;
      idx_r <= idx_nxt; large_r <= large_nxt; blk_num_r <= blk_num_nxt;
      hdr_ok_r <= hdr_ok_nxt; crc_r <= crc_nxt; sum_r <= sum_nxt; rchk_r <= rchk_nxt;
      clen_r <= clen_nxt; dup_r <= dup_nxt; flush_cnt_r <= flush_cnt_nxt;
    end
  end

  // Step logic, written as one ordered pass with small helper actions.
  always_comb begin
    logic [10:0] bufsz;
    logic [10:0] k;
    logic [24:0] addr;
    logic [24:0] room;
    logic        num_ok, prev_ok, chk_ok;
    logic [15:0] lim;
    logic [15:0] rchk_full;
    logic        sync_again;
    logic        do_flush_end;
    logic [7:0]  cnt_inc;
    res_t        r;
    phase_nxt = phase_r; mode_nxt = mode_r; pend_nxt = pend_r; timer_nxt = timer_r;
    sync_cnt_nxt = sync_cnt_r; crc_mode_nxt = crc_mode_r; exp_blk_nxt = exp_blk_r;
    idx_nxt = idx_r; large_nxt = large_r; blk_num_nxt = blk_num_r; hdr_ok_nxt = hdr_ok_r;
    crc_nxt = crc_r; sum_nxt = sum_r; rchk_nxt = rchk_r; clen_nxt = clen_r;
    dup_nxt = dup_r; flush_cnt_nxt = flush_cnt_r;
    res = '0;
    bufsz = large_r ? LARGE_BLK : SMALL_BLK;
    k = idx_r;
    addr = {1'b0, clen_r} + {14'd0, k} - 25'd2;
    room = (cap > {1'b0, clen_r}) ? cap - {1'b0, clen_r} : 25'd0;
    num_ok = 1'b0; prev_ok = 1'b0; chk_ok = 1'b0; rchk_full = '0;
    sync_again = 1'b0; do_flush_end = 1'b0; lim = '0; cnt_inc = '0; r = '0;

    unique case (op)
      OP_START: begin
        clen_nxt = '0; exp_blk_nxt = 8'd1; dup_nxt = max_retrans_r; crc_mode_nxt = 1'b0;
        mode_nxt = MODE_C; pend_nxt = PEND_NONE; flush_cnt_nxt = '0;
        phase_nxt = PH_SYNC; sync_cnt_nxt = '0; timer_nxt = '0;
        r = '0; r.kind = KIND_SEND; r.value = CH_C;
        res.item[0] = r; res.count = 3'd1;
      end
      OP_BYTE: begin
        unique case (phase_r)
          PH_SYNC: begin
            if (rx_byte == CH_SOH || rx_byte == CH_STX) begin
              if (mode_r == MODE_C) crc_mode_nxt = 1'b1;
              mode_nxt = MODE_NONE; phase_nxt = PH_BLOCK;
              large_nxt = (rx_byte == CH_STX); idx_nxt = '0; crc_nxt = '0; sum_nxt = '0;
              rchk_nxt = '0; hdr_ok_nxt = 1'b0; timer_nxt = '0;
            end else if (rx_byte == CH_EOT) begin
              phase_nxt = PH_FLUSH; pend_nxt = PEND_END; timer_nxt = '0; flush_cnt_nxt = '0;
            end else if (rx_byte == CH_CAN) begin
              phase_nxt = PH_CANWAIT; timer_nxt = '0;
            end else sync_again = 1'b1;
          end
          PH_CANWAIT: begin
            if (rx_byte == CH_CAN) begin
              phase_nxt = PH_FLUSH; pend_nxt = PEND_CANCEL; timer_nxt = '0;
              flush_cnt_nxt = '0;
            end else sync_again = 1'b1;
          end
          PH_BLOCK: begin
            timer_nxt = '0;
            idx_nxt = k + 11'd1;
            if (k == 11'd0) blk_num_nxt = rx_byte;
            else if (k == 11'd1) hdr_ok_nxt = (rx_byte == ~blk_num_r);
            else if (k < bufsz + 11'd2) begin
              crc_nxt = crc_byte(crc_r, rx_byte);
              sum_nxt = sum_r + rx_byte;
              if (hdr_ok_r && blk_num_r == exp_blk_r && addr < cap) begin
                r = '0; r.kind = KIND_STORE; r.value = rx_byte; r.addr = addr[23:0];
                res.item[0] = r; res.count = 3'd1;
              end
            end else if (crc_mode_r && k == bufsz + 11'd2) begin
              rchk_nxt = {rx_byte, 8'h00};
            end else begin
              rchk_full = crc_mode_r ? {rchk_r[15:8], rx_byte} : {8'h00, rx_byte};
              rchk_nxt = rchk_full;
              num_ok = (blk_num_r == exp_blk_r);
              prev_ok = (blk_num_r == exp_blk_r - 8'd1);
              chk_ok = crc_mode_r ? (crc_r == rchk_full) : (sum_r == rchk_full[7:0]);
              if (hdr_ok_r && (num_ok || prev_ok) && chk_ok) begin
                if (num_ok) begin
                  clen_nxt = clen_r + ((room < {14'd0, bufsz}) ? room[23:0]
                                                               : {13'd0, bufsz});
                  exp_blk_nxt = exp_blk_r + 8'd1;
                  dup_nxt = max_retrans_r;
                end else dup_nxt = dup_r - 8'd1;
                if ((num_ok && max_retrans_r == 8'd0) || (!num_ok && dup_r <= 8'd1)) begin
                  dup_nxt = num_ok ? max_retrans_r : dup_r;
                  phase_nxt = PH_FLUSH; pend_nxt = PEND_DUPS; timer_nxt = '0;
                  flush_cnt_nxt = '0;
                end else begin
                  phase_nxt = PH_SYNC; sync_cnt_nxt = '0; timer_nxt = '0;
                  r = '0; r.kind = KIND_SEND; r.value = CH_ACK; res.item[0] = r;
                  res.count = 3'd1;
                  if (mode_r != MODE_NONE) begin
                    r.value = (mode_r == MODE_C) ? CH_C : CH_NAK;
                    res.item[1] = r; res.count = 3'd2;
                  end
                end
              end else begin
                phase_nxt = PH_FLUSH; pend_nxt = PEND_NAK; timer_nxt = '0;
                flush_cnt_nxt = '0;
              end
            end
          end
          PH_FLUSH: begin
            if (flush_cnt_r >= FLUSH_MAX) do_flush_end = 1'b1;
            else begin
              flush_cnt_nxt = flush_cnt_r + 3'd1; timer_nxt = '0;
            end
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (phase_r != PH_IDLE && phase_r <= PH_FLUSH) begin
          timer_nxt = (timer_r != 16'hFFFF) ? timer_r + 16'd1 : timer_r;
          lim = (phase_r == PH_SYNC) ? sync_wait_r :
                (phase_r == PH_FLUSH) ? flush_wait_r : byte_wait_r;
          if (timer_nxt >= lim) begin
            if (phase_r == PH_BLOCK) begin
              phase_nxt = PH_FLUSH; pend_nxt = PEND_NAK; timer_nxt = '0;
              flush_cnt_nxt = '0;
            end else if (phase_r == PH_FLUSH) do_flush_end = 1'b1;
            else sync_again = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // Next sync attempt: count it, switch mode or give up.
    if (sync_again) begin
      cnt_inc = sync_cnt_r + 8'd1;
      phase_nxt = PH_SYNC;
      timer_nxt = '0;
      r = '0; r.kind = KIND_SEND;
      if (cnt_inc >= sync_tries_r || cnt_inc == 8'd0) begin
        if (mode_r == MODE_C) begin
          mode_nxt = MODE_NAK; sync_cnt_nxt = '0;
          r.value = CH_NAK; res.item[0] = r; res.count = 3'd1;
        end else begin
          sync_cnt_nxt = cnt_inc;
          phase_nxt = PH_FLUSH; pend_nxt = PEND_SYNCFAIL; flush_cnt_nxt = '0;
        end
      end else begin
        sync_cnt_nxt = cnt_inc;
        if (mode_r != MODE_NONE) begin
          r.value = (mode_r == MODE_C) ? CH_C : CH_NAK;
          res.item[0] = r; res.count = 3'd1;
        end
      end
    end

    // End of a flush carries out the pending action.
    if (do_flush_end) begin
      pend_nxt = PEND_NONE;
      r = '0; r.kind = KIND_SEND;
      case (pend_r)
        PEND_END, PEND_CANCEL: begin
          r.value = CH_ACK; res.item[0] = r;
          r = '0; r.kind = KIND_FINISH; r.len = clen_r;
          r.status = (pend_r == PEND_END) ? ST_NORMAL : ST_CANCEL;
          res.item[1] = r; res.count = 3'd2; phase_nxt = PH_IDLE;
        end
        PEND_SYNCFAIL, PEND_DUPS: begin
          r.value = CH_CAN; res.item[0] = r; res.item[1] = r; res.item[2] = r;
          r = '0; r.kind = KIND_FINISH; r.len = clen_r;
          r.status = (pend_r == PEND_DUPS) ? ST_DUPS : ST_SYNCFAIL;
          res.item[3] = r; res.count = 3'd4; phase_nxt = PH_IDLE;
        end
        PEND_NAK: begin
          r.value = CH_NAK; res.item[0] = r; res.count = 3'd1;
          phase_nxt = PH_SYNC; sync_cnt_nxt = '0; timer_nxt = '0;
          if (mode_r != MODE_NONE) begin
            r.value = (mode_r == MODE_C) ? CH_C : CH_NAK;
            res.item[1] = r; res.count = 3'd2;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/xmr_outq.sv
// Result buffer of the XMODEM receiver: holds the results of up to two
// steps and drains them one a cycle while out_tready is high, with tlast. Depends on xmr_pkg.
module xmr_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  xmr_pkg::res_list_t list,
  output logic               space,
  output logic               out_tvalid,
  input  logic               out_tready,
  output xmr_pkg::res_t      out_item,
  output logic               out_last
);
  import xmr_pkg::*;

  // Two slots, each one step's list; rd picks a slot, pos an entry.
  res_list_t   slot_r [2];
  logic [1:0]  full_r, full_nxt;
  logic        rd_r, wr_r;
  logic [1:0]  pos_r;
  logic        pop, done, take;
  res_list_t   cur;

  assign cur = slot_r[rd_r];
  assign out_tvalid = full_r[rd_r];
  assign out_item = cur.item[pos_r];
  assign out_last = ({1'b0, pos_r} == cur.count - 3'd1);
  assign pop = out_tvalid && out_tready;
  assign done = pop && out_last;
  assign take = push && list.count != 3'd0;
  assign space = !full_r[wr_r] || (done && rd_r == wr_r);

  // Slot occupancy: a drained slot frees, a pushed slot fills.
  always_comb begin
    full_nxt = full_r;
    if (done) full_nxt[rd_r] = 1'b0;
    if (take) full_nxt[wr_r] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (take) slot_r[wr_r] <= list;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= '0; rd_r <= 1'b0; wr_r <= 1'b0; pos_r <= '0;
    end else begin
      full_r <= full_nxt;
      if (done) begin
        rd_r <= ~rd_r; pos_r <= '0;
      end else if (pop) pos_r <= pos_r + 2'd1;
      if (take) wr_r <= ~wr_r;
    end
  end

endmodule

FILE: rtl/xmodem_receiver_unit.sv
// XMODEM receiver top level: stream ports, step logic and result buffer.
// The first result of an item is offered in the cycle after the item is
// accepted when the result buffer is empty.
// Inputs are accepted one item per cycle while the two-slot result buffer
// has a free slot; each result leaves on an accepted output transfer.
// Reset (synchronous, rst_n low) restores register defaults, idle phase.
module xmodem_receiver_unit #(
  parameter int ADDR_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // op[1:0], rx_byte[9:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // kind[1:0], value[9:2], store_address[33:10],
                                  // status[35:34], received_length[59:36]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [23:0] cfg_data
);
  import xmr_pkg::*;

  res_list_t list;
  res_t      item;
  logic      space, step;

  assign in_tready = space;
  assign step = in_tvalid && space;

  xmr_core #(.ADDR_BITS(ADDR_BITS)) u_core (
    .clk, .rst_n, .step, .op(in_tdata[1:0]), .rx_byte(in_tdata[9:2]),
    .cfg_we, .cfg_idx, .cfg_data, .res(list)
  );

  // Results are latched at the same edge the step state advances.
  xmr_outq u_q (
    .clk, .rst_n, .push(step), .list, .space,
    .out_tvalid, .out_tready, .out_item(item), .out_last(out_tlast)
  );

  assign out_tdata = {4'd0, item.len, item.status, item.addr, item.value, item.kind};

endmodule
